// File: sv/assert_macros.svh
// Assertion macros for the top-level RTL file, the one that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/udppc_pkg.sv
// Package with the beat types, protocol constants and internal structs.
`timescale 1ns / 1ps

package udppc_pkg;

    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] LEN_MAX       = 16'hFFFF;
    localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
    localparam logic [15:0] IPV4_MIN_LEN  = 16'd34;
    localparam logic [15:0] IPV6_MIN_LEN  = 16'd54;
    localparam logic [15:0] IPV6_UDP_OFF  = 16'd54;
    localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

    // Byte positions of the header fields that the verdict needs.
    localparam logic [15:0] POS_ETYPE_HI  = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO  = 16'd13;
    localparam logic [15:0] POS_IHL       = 16'd14;
    localparam logic [15:0] POS_NEXT_HDR  = 16'd20;
    localparam logic [15:0] POS_PROTO     = 16'd23;
    localparam logic [15:0] POS_DPORT6_HI = 16'd56;
    localparam logic [15:0] POS_DPORT6_LO = 16'd57;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic        verdict;
        logic        matched;
        logic [15:0] frame_length;
        logic [63:0] packet_total;
        logic [63:0] byte_total;
    } out_t;

    // Per-frame decision handed from the parser to the counter stage.
    typedef struct packed {
        logic        verdict;
        logic        matched;
        logic [15:0] frame_length;
    } judge_t;

endpackage

// File: sv/udppc_parse.sv
// Header field capture and per-frame pass/drop decision.
`timescale 1ns / 1ps

module udppc_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat_accept,
    input  udppc_pkg::in_t    beat,
    input  logic [15:0]       match_port,
    output udppc_pkg::judge_t judge
);
    import udppc_pkg::*;

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [7:0]  etype_hi_reg;
    logic [7:0]  etype_lo_reg;
    logic [3:0]  ihl_reg;
    logic [7:0]  next_hdr_reg;
    logic [7:0]  proto_reg;
    logic [7:0]  dport4_hi_reg;
    logic [7:0]  dport4_lo_reg;
    logic [7:0]  dport6_hi_reg;
    logic [7:0]  dport6_lo_reg;

    logic [15:0] off4;
    logic [15:0] frame_len;
    logic [15:0] etype;
    logic        is_v4;
    logic        is_v6;
    logic [15:0] udp_off;
    logic [15:0] dport;
    logic        drop;

    // The IPv4 UDP offset follows the IHL nibble, which is stored two bytes
    // before the earliest possible port byte, so it is settled in time.
    assign off4 = ETH_HDR_LEN + {10'd0, ihl_reg, 2'b00};

    always_comb
    begin
        pos_next = pos_reg;
        if (beat.last_byte)
            pos_next = '0;
        else if (pos_reg != LEN_MAX)
            pos_next = pos_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (beat_accept)
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (beat_accept)
        begin
            if (pos_reg == POS_ETYPE_HI)
                etype_hi_reg <= beat.data_byte;
            if (pos_reg == POS_ETYPE_LO)
                etype_lo_reg <= beat.data_byte;
            if (pos_reg == POS_IHL)
                ihl_reg <= beat.data_byte[3:0];
            if (pos_reg == POS_NEXT_HDR)
                next_hdr_reg <= beat.data_byte;
            if (pos_reg == POS_PROTO)
                proto_reg <= beat.data_byte;
            if (pos_reg == off4 + 16'd2)
                dport4_hi_reg <= beat.data_byte;
            if (pos_reg == off4 + 16'd3)
                dport4_lo_reg <= beat.data_byte;
            if (pos_reg == POS_DPORT6_HI)
                dport6_hi_reg <= beat.data_byte;
            if (pos_reg == POS_DPORT6_LO)
                dport6_lo_reg <= beat.data_byte;
        end
    end

    // Every field the decision reads lies well before the last byte whenever
    // the length checks let the decision depend on it.
    always_comb
    begin
        frame_len = (pos_reg == LEN_MAX) ? LEN_MAX : pos_reg + 16'd1;
        etype     = {etype_hi_reg, etype_lo_reg};
        is_v4     = (etype == ETYPE_IPV4);
        is_v6     = (etype == ETYPE_IPV6);
        udp_off   = is_v4 ? off4 : IPV6_UDP_OFF;
        dport     = is_v4 ? {dport4_hi_reg, dport4_lo_reg} : {dport6_hi_reg, dport6_lo_reg};
        drop      = (frame_len >= ETH_HDR_LEN)
                    && ((is_v4 && frame_len >= IPV4_MIN_LEN && proto_reg == PROTO_UDP)
                        || (is_v6 && frame_len >= IPV6_MIN_LEN
                            && next_hdr_reg == PROTO_UDP))
                    && (udp_off + UDP_HDR_LEN <= frame_len);

        judge.verdict      = drop;
        judge.matched      = drop && (dport == match_port);
        judge.frame_length = frame_len;
    end

endmodule

// File: sv/udp_port_packet_counter.sv
// Top level: UDP destination port filter with matched packet and byte counters.
// Two register stages: a frame's decision is loaded with its last beat and moves to
// the result stage when it has room. Throughput: one beat per cycle; the input
// stalls only while both stages hold results and the result side is not ready.
// Reset (rst_n low, asynchronous) clears the byte position, both counters,
// the match port and all valid flags; captured header bytes are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udp_port_packet_counter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_ready,
    input  udppc_pkg::in_t   frame_beat,
    output logic             result_valid,
    input  logic             result_ready,
    output udppc_pkg::out_t  result,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data
);
    import udppc_pkg::*;

    logic [15:0] port_reg;

    // Stage one holds the decision for a finished frame; stage two holds the
    // result beat with the updated totals.
    judge_t      judge;
    judge_t      s1_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    out_t        out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] pkt_cnt_reg;
    logic [63:0] pkt_cnt_next;
    logic [63:0] byte_cnt_reg;
    logic [63:0] byte_cnt_next;

    logic        beat_accept;
    logic        out_room;
    logic        s1_adv;
    logic        s1_load;

    // Ready chains backward: a stage takes new data when it is empty or its
    // content moves on in the same cycle.
    assign out_room    = !out_valid_reg || result_ready;
    assign s1_adv      = s1_valid_reg && out_room;
    assign frame_ready = !s1_valid_reg || out_room;
    assign beat_accept = frame_valid && frame_ready;
    assign s1_load     = beat_accept && frame_beat.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            port_reg <= '0;
        else if (cfg_wr_en)
            port_reg <= cfg_wr_data;
    end

    udppc_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_accept (beat_accept),
        .beat        (frame_beat),
        .match_port  (port_reg),
        .judge       (judge)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;

        pkt_cnt_next  = pkt_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        if (s1_adv && s1_reg.matched)
        begin
            pkt_cnt_next  = pkt_cnt_reg + 64'd1;
            byte_cnt_next = byte_cnt_reg + {48'd0, s1_reg.frame_length};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pkt_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

    // Payload registers load only when their stage takes a new frame.
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_reg <= judge;
        if (s1_adv)
        begin
            out_reg.verdict      <= s1_reg.verdict;
            out_reg.matched      <= s1_reg.matched;
            out_reg.frame_length <= s1_reg.frame_length;
            out_reg.packet_total <= pkt_cnt_next;
            out_reg.byte_total   <= byte_cnt_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A counted frame is always a dropped frame.
    `ASSERT_SAME(a_match_is_drop, clk, rst_n, result_valid && result.matched, result.verdict)
    // Every frame holds at least its last byte.
    `ASSERT_SAME(a_len_nonzero, clk, rst_n, result_valid, result.frame_length != 16'd0)
    // A counted frame bumps the packet counter by exactly one.
    `ASSERT_NEXT(a_pkt_inc, clk, rst_n, s1_adv && s1_reg.matched,
        pkt_cnt_reg == $past(pkt_cnt_reg) + 64'd1)
    // Without a counted frame the packet counter holds.
    `ASSERT_NEXT(a_pkt_hold, clk, rst_n, !(s1_adv && s1_reg.matched),
        pkt_cnt_reg == $past(pkt_cnt_reg))

endmodule

// File: bench/udp_count_checker.sv
// Checker that predicts each frame's verdict and counters and compares the result beats.
`timescale 1ns / 1ps

module udp_count_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    input  logic             frame_ready,
    input  udppc_pkg::in_t   frame_beat,
    input  logic             result_valid,
    input  logic             result_ready,
    input  udppc_pkg::out_t  result,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    output int unsigned      mismatches,
    output int unsigned      pending
);
    import udppc_pkg::*;

    localparam int unsigned STORE_DEPTH  = 82;
    localparam int unsigned REPORT_LIMIT = 10;

    logic [7:0]  hdr_bytes [0:STORE_DEPTH-1];
    logic [15:0] frame_pos   = '0;
    logic [15:0] port_sel    = '0;
    logic [63:0] pkt_count   = '0;
    logic [63:0] octet_count = '0;
    out_t        verdict_q [$];
    int unsigned fail_total  = 0;
    int unsigned queued      = 0;

    assign mismatches = fail_total;
    assign pending    = queued;

    // Decides drop or pass for a frame of len bytes and gives the UDP header offset.
    function automatic logic judge_frame(input logic [15:0] len, output logic [15:0] udp_at);
        logic [15:0] etype;
        logic [15:0] off;
        udp_at = '0;
        if (len < ETH_HDR_LEN)
            return 1'b0;
        etype = {hdr_bytes[POS_ETYPE_HI], hdr_bytes[POS_ETYPE_LO]};
        if (etype == ETYPE_IPV4)
        begin
            if (len < IPV4_MIN_LEN || hdr_bytes[POS_PROTO] != PROTO_UDP)
                return 1'b0;
            off = ETH_HDR_LEN + {10'd0, hdr_bytes[POS_IHL][3:0], 2'b00};
        end
        else if (etype == ETYPE_IPV6)
        begin
            if (len < IPV6_MIN_LEN || hdr_bytes[POS_NEXT_HDR] != PROTO_UDP)
                return 1'b0;
            off = IPV6_UDP_OFF;
        end
        else
        begin
            return 1'b0;
        end
        if (off + UDP_HDR_LEN > len)
            return 1'b0;
        udp_at = off;
        return 1'b1;
    endfunction

    // Prints one result beat with a label in front.
    task automatic show_beat(input string tag, input out_t beat);
        $display("%0t: %s verdict %0d matched %0d length %0d packets %0d bytes %0d",
                 $realtime, tag, beat.verdict, beat.matched, beat.frame_length,
                 beat.packet_total, beat.byte_total);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic        drop;
        logic        hit;
        logic [15:0] udp_at;
        out_t        want;
        if (!rst_n)
        begin
            frame_pos   = '0;
            port_sel    = '0;
            pkt_count   = '0;
            octet_count = '0;
            verdict_q.delete();
            queued      = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        show_beat("result beat with nothing expected:", result);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.verdict !== want.verdict || result.matched !== want.matched ||
                        result.frame_length !== want.frame_length ||
                        result.packet_total !== want.packet_total ||
                        result.byte_total !== want.byte_total)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                        begin
                            show_beat("result mismatch, expected", want);
                            show_beat("result mismatch, got     ", result);
                        end
                    end
                end
            end

            if (cfg_wr_en)
                port_sel = cfg_wr_data;

            if (frame_valid && frame_ready)
            begin
                if (frame_pos < STORE_DEPTH)
                    hdr_bytes[frame_pos] = frame_beat.data_byte;
                if (frame_pos != LEN_MAX)
                    frame_pos = frame_pos + 16'd1;
                if (frame_beat.last_byte)
                begin
                    drop = judge_frame(frame_pos, udp_at);
                    hit  = drop ? ({hdr_bytes[udp_at + 16'd2], hdr_bytes[udp_at + 16'd3]}
                                   == port_sel) : 1'b0;
                    if (hit)
                    begin
                        pkt_count   = pkt_count + 64'd1;
                        octet_count = octet_count + {48'd0, frame_pos};
                    end
                    want.verdict      = drop;
                    want.matched      = hit;
                    want.frame_length = frame_pos;
                    want.packet_total = pkt_count;
                    want.byte_total   = octet_count;
                    verdict_q.push_back(want);
                    frame_pos = '0;
                end
            end
            queued = verdict_q.size();
        end
    end

endmodule

// File: bench/tb.sv
// Testbench top: drives frames and port settings into the UDP port counter and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import udppc_pkg::*;

    // The run is bounded by this many clock cycles, which leaves room for the slowest
    // correct run, with every beat and every result waiting out the longest gap.
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    // Quiet cycles before a port write and at the end, after the last owed result is back.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Beats of random frames; together with the directed frames the run sends
    // about 1300 beats.
    localparam int unsigned RANDOM_BEATS  = 320;
    localparam int unsigned PHASES        = 4;
    localparam int unsigned PHASE_FRAMES  = 2;

    // Protocol codes that the block must not take for UDP.
    localparam logic [15:0] ETYPE_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        frame_valid  = 1'b0;
    logic        frame_ready;
    in_t         frame_beat   = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_t        result;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = '0;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned cycle_count  = 0;

    // When a burst flag is set, that side runs without idle cycles.
    logic        tx_burst     = 1'b0;
    logic        rx_burst     = 1'b0;
    logic [15:0] cur_port     = '0;
    logic [7:0]  frame_bytes [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    udp_port_packet_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame_beat   (frame_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // The checker watches both channels and the port writes, predicts every result
    // and compares; it hands back its failure count and how many results are owed.
    udp_count_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame_beat   (frame_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A hung handshake or a missing result ends the run here.
    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("[udp_port_packet_counter] ERROR");
        $finish;
    end

    // Overwrites one byte of the frame under construction if the frame reaches it.
    function automatic void put(input int idx, input logic [7:0] val);
        if (idx < frame_bytes.size())
            frame_bytes[idx] = val;
    endfunction

    // Fills a frame of len random bytes and then lays the header fields over it.
    // For IPv4 the IHL nibble sets where the port lands; for every other ethertype
    // the IPv6 positions are written, which means nothing when the ethertype is foreign.
    function automatic void build_frame(input int len, input logic [15:0] etype,
                                        input logic [3:0] ihl, input logic [7:0] proto,
                                        input logic [15:0] dport);
        int udp_at;
        frame_bytes.delete();
        repeat (len)
            frame_bytes.push_back(8'($urandom));
        put(int'(POS_ETYPE_HI), etype[15:8]);
        put(int'(POS_ETYPE_LO), etype[7:0]);
        if (etype == ETYPE_IPV4)
        begin
            // The version nibble is random; only the low nibble matters.
            put(int'(POS_IHL), {4'($urandom), ihl});
            put(int'(POS_PROTO), proto);
            udp_at = int'(ETH_HDR_LEN) + 4 * int'(ihl);
        end
        else
        begin
            put(int'(POS_NEXT_HDR), proto);
            udp_at = int'(IPV6_UDP_OFF);
        end
        put(udp_at + 2, dport[15:8]);
        put(udp_at + 3, dport[7:0]);
    endfunction

    // Offers one beat after a random idle gap and returns at the falling edge after
    // it is taken. Valid stays high between back-to-back beats.
    task automatic push_beat(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_valid <= 1'b1;
        frame_beat  <= '{data_byte: data, last_byte: last};
        @(posedge clk);
        while (!(frame_valid && frame_ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            push_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drops valid and waits until every owed result has come back, then lets the
    // pipeline drain before anything touches the port register.
    task automatic settle();
        frame_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_port(input logic [15:0] port);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= port;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_port = port;
    endtask

    // Builds a random frame. Most frames are well-formed UDP over IPv4 or IPv6 with
    // the current port, a near port or a random one; the rest carry other protocols,
    // near-miss ethertypes, random headers, or are cut short.
    function automatic void random_frame();
        int unsigned pick;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] etype;
        logic [15:0] dport;
        int          min_len;
        int          len;
        pick  = $urandom_range(0, 99);
        ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        proto = ($urandom_range(0, 7) == 0) ? 8'($urandom) : PROTO_UDP;
        case ($urandom_range(0, 3))
            0:       dport = 16'($urandom);
            1:       dport = cur_port ^ (16'd1 << $urandom_range(0, 15));
            default: dport = cur_port;
        endcase
        if (pick < 50)
        begin
            etype   = ETYPE_IPV4;
            min_len = int'(ETH_HDR_LEN) + 4 * int'(ihl) + int'(UDP_HDR_LEN);
            if (min_len < int'(IPV4_MIN_LEN))
                min_len = int'(IPV4_MIN_LEN);
        end
        else if (pick < 80)
        begin
            etype   = ETYPE_IPV6;
            min_len = int'(IPV6_UDP_OFF) + int'(UDP_HDR_LEN);
        end
        else if (pick < 90)
        begin
            // One flipped bit away from a recognized ethertype.
            etype   = ($urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_IPV6)
                      ^ (16'd1 << $urandom_range(0, 15));
            min_len = int'(IPV6_UDP_OFF) + int'(UDP_HDR_LEN);
        end
        else
        begin
            etype   = 16'($urandom);
            min_len = int'(ETH_HDR_LEN);
        end
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(1, min_len - 1);
        else if ($urandom_range(0, 7) == 0)
            len = min_len + $urandom_range(0, 120);
        else
            len = min_len + $urandom_range(0, 12);
        build_frame(len, etype, ihl, proto, dport);
    endfunction

    // Result side: each result waits a random stall, with stretches of none.
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!(result_valid && result_ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        int unsigned phase_beats;
        int unsigned phase_frames;
        logic [15:0] port;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames with the port at its reset value of zero.
        // Frames too short to hold an Ethernet header.
        build_frame(1, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(13, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        // IPv4 frames that end with the Ethernet header, inside the IP header or inside the UDP header.
        build_frame(14, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(33, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(41, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        // Shortest complete IPv4 UDP frame, matched.
        build_frame(42, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        // An IHL of zero puts the UDP header right after the Ethernet header.
        build_frame(34, ETYPE_IPV4, 4'd0, PROTO_UDP, 16'h0000);
        send_frame();
        // The largest IHL puts the UDP header at the end of the stored bytes.
        build_frame(81, ETYPE_IPV4, 4'd15, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(82, ETYPE_IPV4, 4'd15, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(34, ETYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000);
        send_frame();
        // IPv6: cut in the fixed header, cut in the UDP header, complete, and not UDP.
        build_frame(53, ETYPE_IPV6, 4'd0, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(61, ETYPE_IPV6, 4'd0, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(62, ETYPE_IPV6, 4'd0, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(54, ETYPE_IPV6, 4'd0, PROTO_ICMPV6, 16'h0000);
        send_frame();
        // Foreign ethertypes, among them the IPv4 code with its bytes swapped.
        build_frame(34, ETYPE_ARP, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        build_frame(34, {ETYPE_IPV4[7:0], ETYPE_IPV4[15:8]}, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();
        // Dropped but not counted: the port differs.
        build_frame(42, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'hFFFF);
        send_frame();
        build_frame(62, ETYPE_IPV6, 4'd0, PROTO_UDP, 16'h8000);
        send_frame();
        // Bytes past the stored header must not disturb the decision.
        build_frame(100, ETYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000);
        send_frame();

        // Random phases, each with its own port: both extremes, a random value and
        // the top bit alone.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       port = 16'hFFFF;
                1:       port = 16'h0000;
                3:       port = 16'h8000;
                default: port = 16'($urandom);
            endcase
            write_port(port);
            phase_beats  = 0;
            phase_frames = 0;
            while (phase_beats < RANDOM_BEATS / PHASES || phase_frames < PHASE_FRAMES)
            begin
                tx_burst = ($urandom_range(0, 4) == 0);
                random_frame();
                send_frame();
                phase_beats  += frame_bytes.size();
                phase_frames += 1;
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("[udp_port_packet_counter] OK");
        else
            $display("[udp_port_packet_counter] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/udppc_pkg.sv
sv/udppc_parse.sv
sv/udp_port_packet_counter.sv
bench/udp_count_checker.sv
bench/tb.sv
